FILE: rtl/core/itd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intercom telegram decoder package
// Telegram kind codes, opcode nibbles and the decoded result record.
// ----------------------------------------------------------------------------
package itd_pkg;

    typedef enum logic [4:0] {
        K_UNKNOWN           = 5'd0,
        K_ACK_STATUS        = 5'd1,
        K_ACK_DATA          = 5'd2,
        K_SEARCH_STATIONS   = 5'd3,
        K_FOUND_STATION     = 5'd4,
        K_DOOR_CALL         = 5'd5,
        K_FLOOR_CALL        = 5'd6,
        K_INTERNAL_CALL     = 5'd7,
        K_CONTROL_FUNC      = 5'd8,
        K_START_TALK_DOOR   = 5'd9,
        K_START_TALK        = 5'd10,
        K_STOP_TALK_DOOR    = 5'd11,
        K_STOP_TALK         = 5'd12,
        K_OPEN_DOOR         = 5'd13,
        K_OPEN_DOOR_LONG    = 5'd14,
        K_LIGHT             = 5'd15,
        K_DOOR_OPENED       = 5'd16,
        K_DOOR_CLOSED       = 5'd17,
        K_END_RINGTONE      = 5'd18,
        K_END_DOOR_READY    = 5'd19,
        K_INIT_DOOR_STATION = 5'd20,
        K_DEVICE_RESET      = 5'd21,
        K_SEL_GROUP         = 5'd22,
        K_SEL_GROUP_RESET   = 5'd23,
        K_SEARCH_DEVICES    = 5'd24,
        K_FOUND_DEVICE      = 5'd25,
        K_FOUND_DEVICE_SUB  = 5'd26,
        K_PROG_MODE         = 5'd27,
        K_READ_MEM          = 5'd28,
        K_SEL_MEM_PAGE      = 5'd29,
        K_WRITE_MEM         = 5'd30,
        K_REQ_VERSION       = 5'd31
    } t_kind;

    typedef struct packed {
        logic [19:0] serial;
        logic [31:0] payload;
        logic [7:0]  addr;
        t_kind       kind;
    } t_result;

    typedef struct packed {
        logic retx;
        logic response;
        logic long_frame;
    } t_flags;

    // long frame opcode, bits 31..28
    localparam logic [3:0] LOP_CALL    = 4'h0;
    localparam logic [3:0] LOP_OPEN    = 4'h1;
    localparam logic [3:0] LOP_TALK    = 4'h3;
    localparam logic [3:0] LOP_DEVICE  = 4'h5;
    localparam logic [3:0] LOP_CONTROL = 4'h6;
    localparam logic [3:0] LOP_STATION = 4'h7;
    localparam logic [3:0] LOP_MEMORY  = 4'h8;

    // long device sub-op, bits 7..4
    localparam logic [3:0] LDEV_FOUND   = 4'h1;
    localparam logic [3:0] LDEV_SUB     = 4'h4;
    localparam logic [3:0] LDEV_VERSION = 4'hC;

    // long memory sub-op, bits 27..24
    localparam logic [3:0] LMEM_PAGE   = 4'h1;
    localparam logic [3:0] LMEM_PAGE_B = 4'h9;
    localparam logic [3:0] LMEM_WRITE  = 4'h2;

    localparam logic [7:0] FLOOR_CALL_BYTE = 8'h41;
    localparam logic [7:0] STATION_MARK    = 8'h7F;

    // short frame opcode, bits 15..12
    localparam logic [3:0] SOP_OPEN   = 4'h1;
    localparam logic [3:0] SOP_DOOR   = 4'h2;
    localparam logic [3:0] SOP_TALK   = 4'h3;
    localparam logic [3:0] SOP_SETUP  = 4'h5;
    localparam logic [3:0] SOP_SEARCH = 4'h7;
    localparam logic [3:0] SOP_MEMORY = 4'h8;

    // short sub-ops, bits 11..8 (SSET_PROG_MARK is matched on bits 7..4)
    localparam logic [3:0] SOPEN_DOOR  = 4'h1;
    localparam logic [3:0] SOPEN_LIGHT = 4'h2;

    localparam logic [3:0] SDOOR_STATE = 4'h1;
    localparam logic [3:0] SDOOR_RING  = 4'h2;
    localparam logic [3:0] SDOOR_READY = 4'h4;
    localparam logic [3:0] SDOOR_INIT  = 4'h8;

    localparam logic [3:0] SSET_PROG      = 4'h0;
    localparam logic [3:0] SSET_RESET     = 4'h1;
    localparam logic [3:0] SSET_SEARCH    = 4'h2;
    localparam logic [3:0] SSET_GROUP     = 4'h8;
    localparam logic [3:0] SSET_GROUP_RST = 4'h9;
    localparam logic [3:0] SSET_PROG_MARK = 4'h4;

    localparam logic [3:0] SMEM_PAGE = 4'h1;
    localparam logic [3:0] SMEM_READ = 4'h4;

    localparam logic [15:0] SEARCH_WORD = 16'h7FFF;

endpackage

FILE: rtl/core/intercom_telegram_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intercom telegram decoder
// Classifies received bus telegrams into kind, address, payload and serial.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side carries one received telegram per transfer: tdata is the raw
//   32-bit word, tuser the frame flags. Master side returns one decoded
//   result per telegram in the same order, with the flags copied to tuser.
//   A telegram goes into an input register, is decoded by short logic and
//   lands in the result register, where it is offered on the master side:
//   two register stages from port to port. Throughput is one telegram per
//   cycle while m_axis_tready is high; the two stages run as a pipeline.
//   When the receiver stalls, the result register holds, the input stage
//   fills behind it, and s_axis_tready drops once both stages are full.
//   s_axis_tready follows m_axis_tready combinationally through the stages.
//   Reset clears both stage valid flags; nothing else needs initializing.
// ----------------------------------------------------------------------------
module intercom_telegram_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // raw_word
    input  logic [2:0]  s_axis_tuser,   // long_frame, response_frame, retransmitted
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // telegram_kind, device_address,
                                        // payload_value, serial_value, zero fill
    output logic [2:0]  m_axis_tuser    // long_frame_out, response_out, retransmitted_out
);
    import itd_pkg::*;

    logic        r_in_valid;
    logic [31:0] r_in_raw;
    t_flags      r_in_flags;

    logic        r_out_valid;
    t_result     r_out;
    t_flags      r_out_flags;

    t_result     n_out;
    logic        out_load;
    logic        in_load;

    assign out_load      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    itd_decode u_decode (
        .i_raw    (r_in_raw),
        .i_flags  (r_in_flags),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_raw   <= s_axis_tdata;
            r_in_flags <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_out       <= n_out;
            r_out_flags <= r_in_flags;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.serial, r_out.payload, r_out.addr, r_out.kind};
    assign m_axis_tuser  = r_out_flags;

endmodule

FILE: rtl/core/itd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intercom telegram classifier
// Maps one raw telegram and its frame flags to kind, address, payload, serial.
// ----------------------------------------------------------------------------
module itd_decode (
    input  logic [31:0]     i_raw,
    input  itd_pkg::t_flags i_flags,
    output itd_pkg::t_result o_result
);
    import itd_pkg::*;

    t_result r_long;
    t_result r_short;

    always_comb begin
        r_long         = '0;
        r_long.kind    = K_UNKNOWN;
        r_long.serial  = i_raw[27:8];
        unique case (i_raw[31:28])
            LOP_CALL: begin
                r_long.kind = i_raw[6] ? K_INTERNAL_CALL : K_DOOR_CALL;
                r_long.addr = {2'b00, i_raw[5:0]};
            end
            LOP_OPEN: begin
                if (i_raw[7:0] == FLOOR_CALL_BYTE) begin
                    r_long.kind = K_FLOOR_CALL;
                end else if (i_raw[7]) begin
                    r_long.kind    = K_OPEN_DOOR;
                    r_long.addr    = {2'b00, i_raw[5:0]};
                    r_long.payload = {31'd0, i_raw[6]};
                end
            end
            LOP_TALK: begin
                r_long.kind    = i_raw[6] ? K_START_TALK : K_START_TALK_DOOR;
                r_long.addr    = {2'b00, i_raw[5:0]};
                r_long.payload = {31'd0, i_raw[7]};
            end
            LOP_DEVICE: begin
                unique case (i_raw[7:4])
                    LDEV_FOUND: begin
                        r_long.kind = K_FOUND_DEVICE;
                        r_long.addr = {4'd0, i_raw[3:0]};
                    end
                    LDEV_SUB: begin
                        r_long.kind = K_FOUND_DEVICE_SUB;
                        r_long.addr = {4'd0, i_raw[3:0]};
                    end
                    LDEV_VERSION: r_long.kind = K_REQ_VERSION;
                    default: ;
                endcase
            end
            LOP_CONTROL: begin
                r_long.kind    = K_CONTROL_FUNC;
                r_long.payload = {24'd0, i_raw[7:0]};
            end
            LOP_STATION: begin
                if (i_raw[31:24] == STATION_MARK) begin
                    r_long.kind    = K_FOUND_STATION;
                    r_long.payload = {8'd0, i_raw[23:0]};
                    r_long.serial  = '0;
                end
            end
            LOP_MEMORY: begin
                unique case (i_raw[27:24])
                    LMEM_PAGE, LMEM_PAGE_B: begin
                        r_long.kind   = K_SEL_MEM_PAGE;
                        r_long.addr   = {4'd0, i_raw[23:20]};
                        r_long.serial = i_raw[19:0];
                    end
                    LMEM_WRITE: begin
                        r_long.kind    = K_WRITE_MEM;
                        r_long.addr    = i_raw[23:16];
                        r_long.payload = {16'd0, i_raw[15:0]};
                        r_long.serial  = '0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        r_short      = '0;
        r_short.kind = K_UNKNOWN;
        unique case (i_raw[15:12])
            SOP_OPEN: begin
                if (i_raw[11:8] == SOPEN_DOOR) begin
                    r_short.kind    = K_OPEN_DOOR;
                    r_short.addr    = {2'b00, i_raw[5:0]};
                    r_short.payload = {31'd0, i_raw[7]};
                end else if (i_raw[11:8] == SOPEN_LIGHT) begin
                    r_short.kind = K_LIGHT;
                end
            end
            SOP_DOOR: begin
                r_short.addr = {2'b00, i_raw[5:0]};
                unique case (i_raw[11:8])
                    SDOOR_STATE: r_short.kind = i_raw[7] ? K_DOOR_CLOSED : K_DOOR_OPENED;
                    SDOOR_RING:  r_short.kind = K_END_RINGTONE;
                    SDOOR_READY: r_short.kind = K_END_DOOR_READY;
                    SDOOR_INIT:  r_short.kind = K_INIT_DOOR_STATION;
                    default: ;
                endcase
            end
            SOP_TALK: begin
                r_short.kind = i_raw[6] ? K_STOP_TALK : K_STOP_TALK_DOOR;
                r_short.addr = {2'b00, i_raw[5:0]};
            end
            SOP_SETUP: begin
                unique case (i_raw[11:8])
                    SSET_PROG: begin
                        if (i_raw[7:4] == SSET_PROG_MARK) begin
                            r_short.kind    = K_PROG_MODE;
                            r_short.payload = {28'd0, i_raw[3:0]};
                        end
                    end
                    SSET_RESET: begin
                        r_short.kind = K_DEVICE_RESET;
                        r_short.addr = {4'd0, i_raw[3:0]};
                    end
                    SSET_SEARCH: begin
                        r_short.kind    = K_SEARCH_DEVICES;
                        r_short.payload = {28'd0, i_raw[3:0]};
                    end
                    SSET_GROUP: begin
                        r_short.kind    = K_SEL_GROUP;
                        r_short.payload = {28'd0, i_raw[3:0]};
                    end
                    SSET_GROUP_RST: begin
                        r_short.kind    = K_SEL_GROUP_RESET;
                        r_short.payload = {28'd0, i_raw[3:0]};
                    end
                    default: ;
                endcase
            end
            SOP_SEARCH: begin
                if (i_raw[15:0] == SEARCH_WORD) begin
                    r_short.kind = K_SEARCH_STATIONS;
                end
            end
            SOP_MEMORY: begin
                if (i_raw[11:8] == SMEM_PAGE) begin
                    r_short.kind = K_SEL_MEM_PAGE;
                    r_short.addr = i_raw[7:0];
                end else if (i_raw[11:8] == SMEM_READ) begin
                    r_short.kind = K_READ_MEM;
                    r_short.addr = i_raw[7:0];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        if (i_flags.response) begin
            o_result         = '0;
            o_result.kind    = i_flags.long_frame ? K_ACK_DATA : K_ACK_STATUS;
            o_result.payload = i_raw;
        end else if (i_flags.long_frame) begin
            o_result = r_long;
        end else begin
            o_result = r_short;
        end
    end

endmodule
